/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the keyboard FIFO design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define XTKB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define XTKB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/xtkb_pkg.sv */
// Types, codes and the scan code set 1 make-code table for the XT keyboard FIFO.
`default_nettype none

package xtkb_pkg;

  localparam int NUM_KEYS    = 98;
  localparam int KEY_W       = 7;
  localparam int DELAY_W     = 24;
  localparam int QUEUE_DEPTH = 2;  // power of two, pointers wrap naturally

  localparam logic [KEY_W-1:0]   KP_SLASH_ROW = 7'd95;
  localparam logic [7:0]         PREFIX_BYTE  = 8'he0;
  localparam logic [7:0]         BREAK_BIT    = 8'h80;
  localparam logic [7:0]         RESET_REPLY  = 8'h55;
  localparam logic [7:0]         SELF_TEST_OK = 8'haa;
  localparam logic [DELAY_W-1:0] RELOAD_RESET = 24'd1527;

  localparam logic [2:0] FUNC_KEY_DOWN = 3'd0;
  localparam logic [2:0] FUNC_KEY_UP   = 3'd1;
  localparam logic [2:0] FUNC_RAW      = 3'd2;
  localparam logic [2:0] FUNC_CLOCK    = 3'd3;
  localparam logic [2:0] FUNC_ENABLE   = 3'd4;
  localparam logic [2:0] FUNC_TICK     = 3'd5;

  localparam logic [1:0] IRQ_NONE  = 2'd0;
  localparam logic [1:0] IRQ_LOWER = 2'd1;
  localparam logic [1:0] IRQ_RAISE = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEY_DOWN,
    OP_KEY_UP,
    OP_RAW,
    OP_CLOCK,
    OP_ENABLE,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    BK_EXEC,
    BK_SECOND,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [7:0]         code;
    logic               prefix;
    logic               level;
    logic [DELAY_W-1:0] cycles;
  } cmd_t;

  localparam logic [7:0] MAKE_CODE [NUM_KEYS] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14,
    8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c, 8'h1d, 8'h1d,
    8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
    8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31,
    8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h3b,
    8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
    8'h46, 8'h47, 8'h47, 8'h48, 8'h48, 8'h49, 8'h49, 8'h4a, 8'h4b, 8'h4b,
    8'h4c, 8'h4d, 8'h4d, 8'h4e, 8'h4f, 8'h4f, 8'h50, 8'h50, 8'h51, 8'h51,
    8'h1c, 8'h52, 8'h52, 8'h53, 8'h53, 8'h35, 8'h57, 8'h58
  };

endpackage

`default_nettype wire

/* hw/rtl/xtkb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module xtkb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/xtkb_front.sv */
// Front end: accepts input items and turns them into executor commands.
`default_nettype none

module xtkb_front (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_func,
  input  wire logic [xtkb_pkg::KEY_W-1:0]    in_key_index,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic [xtkb_pkg::DELAY_W-1:0]  in_tick_cycles,
  input  wire logic                          q_full,
  output logic                               q_push,
  output xtkb_pkg::cmd_t                     q_cmd
);

  logic key_ok;

  assign key_ok   = (in_key_index < xtkb_pkg::KEY_W'(xtkb_pkg::NUM_KEYS));
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd        = '0;
    q_cmd.op     = xtkb_pkg::OP_NONE;
    q_cmd.key    = in_key_index;
    q_cmd.code   = in_data_byte;
    q_cmd.prefix = (in_key_index == xtkb_pkg::KP_SLASH_ROW);
    q_cmd.level  = |in_data_byte;
    q_cmd.cycles = in_tick_cycles;
    case (in_func)
      xtkb_pkg::FUNC_KEY_DOWN, xtkb_pkg::FUNC_KEY_UP: begin
        // Keys beyond the table become an OP_NONE command here, which the executor only answers with a result.
        if (key_ok) begin
          q_cmd.op   = (in_func == xtkb_pkg::FUNC_KEY_DOWN) ? xtkb_pkg::OP_KEY_DOWN
                                                             : xtkb_pkg::OP_KEY_UP;
          q_cmd.code = xtkb_pkg::MAKE_CODE[in_key_index];
        end
      end
      xtkb_pkg::FUNC_RAW:    q_cmd.op = xtkb_pkg::OP_RAW;
      xtkb_pkg::FUNC_CLOCK:  q_cmd.op = xtkb_pkg::OP_CLOCK;
      xtkb_pkg::FUNC_ENABLE: q_cmd.op = xtkb_pkg::OP_ENABLE;
      xtkb_pkg::FUNC_TICK:   q_cmd.op = xtkb_pkg::OP_TICK;
      default:               q_cmd.op = xtkb_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/xtkb_cmd_queue.sv */
// Short command queue between the front end and the executor.
`default_nettype none

module xtkb_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire xtkb_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output xtkb_pkg::cmd_t      head_cmd
);

  localparam int PTR_W = (xtkb_pkg::QUEUE_DEPTH > 1) ? $clog2(xtkb_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(xtkb_pkg::QUEUE_DEPTH + 1);

  xtkb_pkg::cmd_t   q_mem_r [xtkb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(xtkb_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xtkb_back.sv */
// Executor: keyboard state, scan FIFO, delivery timer and the result register.
`default_nettype none

module xtkb_back #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [xtkb_pkg::DELAY_W-1:0]  cfg_wr_data,
  input  wire logic                          cmd_valid,
  input  wire xtkb_pkg::cmd_t                cmd,
  output logic                               cmd_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_key_byte,
  output logic                               out_key_ready,
  output logic [1:0]                         out_irq_action,
  output logic                               out_overflow
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  xtkb_pkg::bk_state_t state_r, state_nxt;

  logic [PTR_W-1:0]                 rp_r, rp_nxt, rp_inc;
  logic [PTR_W-1:0]                 wp_r, wp_nxt, wp_inc;
  logic [xtkb_pkg::NUM_KEYS-1:0]    marks_r, marks_nxt;
  logic [xtkb_pkg::DELAY_W-1:0]     delay_r, delay_nxt;
  logic [xtkb_pkg::DELAY_W-1:0]     reload_r;
  logic [7:0]                       key_r, key_nxt;
  logic                             pend_r, pend_nxt;
  logic                             clk_line_r, clk_line_nxt;
  logic                             en_line_r, en_line_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [7:0]                       out_key_r;
  logic                             out_pend_r;
  logic [1:0]                       out_irq_r;
  logic                             out_ovf_r;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  logic       full;
  logic       out_free;
  logic       done;
  logic [1:0] irq;
  logic       ovf;
  logic [7:0] last_code;

  xtkb_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_scan_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (rp_r),
    .rd_data (ram_rdata)
  );

  assign wp_inc    = (wp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc    = (rp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  // One slot stays empty so that full and empty differ.
  assign full      = (wp_inc == rp_r);
  assign out_free  = !out_valid_r || out_ready;
  assign last_code = (cmd.op == xtkb_pkg::OP_KEY_UP) ? (cmd.code | xtkb_pkg::BREAK_BIT)
                                                      : cmd.code;

  always_comb begin
    state_nxt    = state_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    marks_nxt    = marks_r;
    delay_nxt    = delay_r;
    key_nxt      = key_r;
    pend_nxt     = pend_r;
    clk_line_nxt = clk_line_r;
    en_line_nxt  = en_line_r;
    ram_we       = 1'b0;
    ram_waddr    = wp_r;
    ram_wdata    = last_code;
    ram_re       = 1'b0;
    done         = 1'b0;
    irq          = xtkb_pkg::IRQ_NONE;
    ovf          = 1'b0;

    case (state_r)
      xtkb_pkg::BK_EXEC: begin
        if (cmd_valid && out_free) begin
          case (cmd.op)
            xtkb_pkg::OP_KEY_DOWN, xtkb_pkg::OP_KEY_UP, xtkb_pkg::OP_RAW: begin
              if (cmd.op == xtkb_pkg::OP_KEY_UP && !marks_r[cmd.key]) begin
                done = 1'b1;
              end else begin
                if (cmd.op != xtkb_pkg::OP_RAW) begin
                  marks_nxt[cmd.key] = (cmd.op == xtkb_pkg::OP_KEY_DOWN);
                end
                if (cmd.op != xtkb_pkg::OP_RAW && cmd.prefix) begin
                  // Keypad slash: the prefix goes now, the code byte from BK_SECOND once the result register is free.
                  if (full) begin
                    ovf  = 1'b1;
                    done = 1'b1;
                  end else begin
                    ram_we    = 1'b1;
                    ram_wdata = xtkb_pkg::PREFIX_BYTE;
                    wp_nxt    = wp_inc;
                    state_nxt = xtkb_pkg::BK_SECOND;
                  end
                end else begin
                  if (full) begin
                    ovf = 1'b1;
                  end else begin
                    ram_we = 1'b1;
                    wp_nxt = wp_inc;
                  end
                  done = 1'b1;
                end
              end
            end
            xtkb_pkg::OP_CLOCK: begin
              done = 1'b1;
              if (cmd.level != clk_line_r) begin
                clk_line_nxt = cmd.level;
                if (cmd.level) begin
                  marks_nxt = '0;
                  delay_nxt = reload_r;
                  key_nxt   = xtkb_pkg::RESET_REPLY;
                  rp_nxt    = '0;
                  wp_nxt    = PTR_W'(1);
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = xtkb_pkg::SELF_TEST_OK;
                end
              end
            end
            xtkb_pkg::OP_ENABLE: begin
              done = 1'b1;
              if (cmd.level != en_line_r) begin
                en_line_nxt = cmd.level;
                if (cmd.level) begin
                  delay_nxt = reload_r;
                end else begin
                  key_nxt  = 8'h00;
                  pend_nxt = 1'b0;
                  irq      = xtkb_pkg::IRQ_LOWER;
                end
              end
            end
            xtkb_pkg::OP_TICK: begin
              if (rp_r != wp_r && clk_line_r && en_line_r && !pend_r) begin
                if (delay_r > cmd.cycles) begin
                  delay_nxt = delay_r - cmd.cycles;
                  done      = 1'b1;
                end else begin
                  ram_re    = 1'b1;
                  state_nxt = xtkb_pkg::BK_READ;
                end
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      xtkb_pkg::BK_SECOND: begin
        if (out_free) begin
          if (full) begin
            ovf = 1'b1;
          end else begin
            ram_we = 1'b1;
            wp_nxt = wp_inc;
          end
          done      = 1'b1;
          state_nxt = xtkb_pkg::BK_EXEC;
        end
      end
      xtkb_pkg::BK_READ: begin
        if (out_free) begin
          key_nxt   = ram_rdata;
          pend_nxt  = 1'b1;
          rp_nxt    = rp_inc;
          delay_nxt = reload_r;
          irq       = xtkb_pkg::IRQ_RAISE;
          done      = 1'b1;
          state_nxt = xtkb_pkg::BK_EXEC;
        end
      end
      default: state_nxt = xtkb_pkg::BK_EXEC;
    endcase

    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xtkb_pkg::BK_EXEC;
      rp_r        <= '0;
      wp_r        <= '0;
      marks_r     <= '0;
      delay_r     <= xtkb_pkg::RELOAD_RESET;
      key_r       <= 8'h00;
      pend_r      <= 1'b0;
      clk_line_r  <= 1'b0;
      en_line_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      marks_r     <= marks_nxt;
      delay_r     <= delay_nxt;
      key_r       <= key_nxt;
      pend_r      <= pend_nxt;
      clk_line_r  <= clk_line_nxt;
      en_line_r   <= en_line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= xtkb_pkg::RELOAD_RESET;
    end else if (cfg_wr_en) begin
      reload_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_key_r  <= key_nxt;
      out_pend_r <= pend_nxt;
      out_irq_r  <= irq;
      out_ovf_r  <= ovf;
    end
  end

  assign cmd_pop        = done;
  assign out_valid      = out_valid_r;
  assign out_key_byte   = out_key_r;
  assign out_key_ready  = out_pend_r;
  assign out_irq_action = out_irq_r;
  assign out_overflow   = out_ovf_r;

endmodule

`default_nettype wire

/* hw/rtl/xt_keyboard_scancode_fifo.sv */
// PC/XT keyboard model with a scan code set 1 FIFO: top level.
// Each input item gives exactly one result item; the byte delay reload register is written via cfg_wr_en.
// The block takes one item per clock while in_ready is high and out_ready does not stall it;
// a keypad-slash key event and a tick that delivers a byte also pass through the BK_SECOND or
// BK_READ executor state, since the scan FIFO memory has one write port and a registered read,
// and the two-entry command queue absorbs that. The scan FIFO keeps FIFO_DEPTH-1 bytes.
`default_nettype none
`include "assert_macros.svh"

module xt_keyboard_scancode_fifo #(
  parameter int FIFO_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [xtkb_pkg::DELAY_W-1:0]  cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_func,
  input  wire logic [xtkb_pkg::KEY_W-1:0]    in_key_index,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic [xtkb_pkg::DELAY_W-1:0]  in_tick_cycles,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_key_byte,
  output logic                               out_key_ready,
  output logic [1:0]                         out_irq_action,
  output logic                               out_overflow
);

  logic           q_full;
  logic           q_push;
  xtkb_pkg::cmd_t q_in_cmd;
  logic           q_valid;
  xtkb_pkg::cmd_t q_head_cmd;
  logic           q_pop;

  xtkb_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_key_index   (in_key_index),
    .in_data_byte   (in_data_byte),
    .in_tick_cycles (in_tick_cycles),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_in_cmd)
  );

  xtkb_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd)
  );

  xtkb_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd_valid      (q_valid),
    .cmd            (q_head_cmd),
    .cmd_pop        (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_byte   (out_key_byte),
    .out_key_ready  (out_key_ready),
    .out_irq_action (out_irq_action),
    .out_overflow   (out_overflow)
  );

  `XTKB_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `XTKB_ASSERT(a_pop_has_cmd, q_pop |-> q_valid, "executor retired a command from an empty queue")
  `XTKB_ASSERT(a_pop_out_free, q_pop |-> (!out_valid || out_ready), "result overwritten before it was taken")
  `XTKB_ASSERT(a_raise_pending, (out_valid && out_irq_action == xtkb_pkg::IRQ_RAISE) |-> out_key_ready, "interrupt raised without a pending byte")
  `XTKB_ASSERT(a_lower_clears, (out_valid && out_irq_action == xtkb_pkg::IRQ_LOWER) |-> (!out_key_ready && out_key_byte == 8'h00), "interrupt lowered but key register not cleared")

endmodule

`default_nettype wire
